// ----- sv/mtps_pkg.sv -----
`default_nettype none
package mtps_pkg;

  localparam int DEF_TONE_DEPTH = 64;
  localparam int MAX_TONE_HZ = 20000;

  localparam int CLK_W = 29;
  localparam int VOL_W = 10;
  localparam int CNT_W = 7;
  localparam int TIME_W = 32;
  localparam int FREQ_W = 16;
  localparam int DUR_W = 16;
  localparam int ADDR_W = 6;
  localparam int PSC_W = 16;
  localparam int PER_W = 29;
  localparam int OUT_W = 32;
  localparam int ENTRY_W = FREQ_W + DUR_W;
  localparam int PROD_W = VOL_W + PER_W;
  localparam int DIV_W = PROD_W;
  localparam int DIVR_W = 16;
  localparam int LEN_W = 6;
  localparam int OP_W = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [OP_W-1:0] OP_POLL = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
  localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_HZ = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VOLUME = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd2;

  localparam logic [CLK_W-1:0] RST_CLOCK_HZ = 29'd16000000;
  localparam logic [VOL_W-1:0] RST_VOLUME = 10'd50;
  localparam logic [CNT_W-1:0] RST_COUNT = 7'd0;

  localparam logic [DIVR_W-1:0] PSC_DIVISOR = 16'd60000;
  localparam logic [DIVR_W-1:0] CMP_DIVISOR = 16'd2000;
  localparam logic [LEN_W-1:0] WORD_LEN = 6'd29;
  localparam logic [LEN_W-1:0] PROD_LEN = 6'd39;
  localparam logic [PSC_W-1:0] PSC_MAX = 16'hFFFF;

  typedef struct packed {
    logic [OP_W-1:0] operation;
    logic [TIME_W-1:0] time_now_ms;
    logic playback_enabled;
    logic [ADDR_W-1:0] entry_address;
    logic [FREQ_W-1:0] entry_frequency;
    logic [DUR_W-1:0] entry_duration;
  } mtps_cmd_t;

  typedef struct packed {
    logic timer_update;
    logic [PSC_W-1:0] prescaler_minus_one;
    logic [OUT_W-1:0] period_minus_one;
    logic [OUT_W-1:0] compare_value;
    logic [ADDR_W-1:0] played_index;
  } mtps_result_t;

  typedef struct packed {
    logic start;
    logic [DIV_W-1:0] dividend;
    logic [DIVR_W-1:0] divisor;
    logic [LEN_W-1:0] len;
  } mtps_div_req_t;

  typedef struct packed {
    logic done;
    logic [DIV_W-1:0] quot;
    logic [DIVR_W-1:0] rem;
  } mtps_div_rsp_t;

  typedef struct packed {
    logic start;
    logic [VOL_W-1:0] multiplier;
    logic [PER_W-1:0] multiplicand;
  } mtps_mul_req_t;

  typedef struct packed {
    logic done;
    logic [PROD_W-1:0] product;
  } mtps_mul_rsp_t;

endpackage
`default_nettype wire

// ----- sv/mtps_ram.sv -----
`default_nettype none
module mtps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input wire logic clk,
  input wire logic we,
  input wire logic [AW-1:0] waddr,
  input wire logic [WIDTH-1:0] wdata,
  input wire logic [AW-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- sv/mtps_div.sv -----
`default_nettype none
module mtps_div
  import mtps_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire mtps_div_req_t req,
  output mtps_div_rsp_t rsp
);

  logic [DIV_W-1:0] quot;
  logic [DIVR_W-1:0] rem;
  logic [DIVR_W-1:0] divisor;
  logic [LEN_W-1:0] count;
  logic busy;
  logic done;
  logic [DIVR_W:0] trial;
  logic [DIVR_W:0] diff;
  logic take;

  assign trial = {rem, quot[DIV_W-1]};
  assign diff = trial - {1'b0, divisor};
  assign take = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        count <= req.len;
      end else if (busy) begin
        count <= count - LEN_W'(1);
        if (count == LEN_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // The dividend is left aligned so that once the last step is done the quotient fills the low bits.
  always_ff @(posedge clk) begin
    if (req.start) begin
      quot <= req.dividend << (LEN_W'(DIV_W) - req.len);
      rem <= '0;
      divisor <= req.divisor;
    end else if (busy) begin
      quot <= {quot[DIV_W-2:0], take};
      rem <= take ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
    end
  end

  assign rsp = '{done: done, quot: quot, rem: rem};

endmodule
`default_nettype wire

// ----- sv/mtps_mul.sv -----
`default_nettype none
module mtps_mul
  import mtps_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire mtps_mul_req_t req,
  output mtps_mul_rsp_t rsp
);

  localparam int MCW = $clog2(VOL_W + 1);

  logic [VOL_W-1:0] mplier;
  logic [PER_W-1:0] mcand;
  logic [PROD_W-1:0] acc;
  logic [MCW-1:0] count;
  logic busy;
  logic done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        count <= MCW'(VOL_W);
      end else if (busy) begin
        count <= count - MCW'(1);
        if (count == MCW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      mplier <= req.multiplier;
      mcand <= req.multiplicand;
      acc <= '0;
    end else if (busy) begin
      mplier <= mplier << 1;
      acc <= (acc << 1) + (mplier[VOL_W-1] ? PROD_W'(mcand) : PROD_W'(0));
    end
  end

  assign rsp = '{done: done, product: acc};

endmodule
`default_nettype wire

// ----- sv/melody_tone_pwm_sequencer_top.sv -----
// A played tone gives its result strobe after the poll is accepted and the index reduction,
// five divider passes and ten multiplier steps are done. A rest or out-of-range frequency
// gives its strobe once the index reduction and the tone read are done. No stall exists.
// Busy drops as the strobe rises, so the next beat can be accepted at the edge ending it.
// Writes, restarts and polls that do not play never raise busy. Synchronous reset clears
// the index and end time and resets the registers; tone memory is undefined until written.
`default_nettype none
module melody_tone_pwm_sequencer_top
  import mtps_pkg::*;
#(
  parameter int TONE_DEPTH = DEF_TONE_DEPTH
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire mtps_cmd_t command,
  output logic busy,
  input wire logic cfg_valid,
  output logic cfg_ready,
  input wire logic [CFG_IDX_W-1:0] cfg_index,
  input wire logic [CLK_W-1:0] cfg_data,
  output logic result_valid,
  output mtps_result_t result
);

  localparam int AW = $clog2(TONE_DEPTH);

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_MOD  = 9'b000000010,
    ST_DATA = 9'b000000100,
    ST_Q1   = 9'b000001000,
    ST_PSC  = 9'b000010000,
    ST_PER  = 9'b000100000,
    ST_FREQ = 9'b001000000,
    ST_MUL  = 9'b010000000,
    ST_CMP  = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;

  logic [CLK_W-1:0] clock_hz;
  logic [VOL_W-1:0] volume;
  logic [CNT_W-1:0] melody_count;
  logic [AW-1:0] tone_index;
  logic [TIME_W-1:0] end_time;
  logic [TIME_W-1:0] now;
  logic [AW-1:0] idx;
  logic [FREQ_W-1:0] freq;
  logic [DUR_W-1:0] dur;
  logic [PSC_W-1:0] psc;
  logic [PER_W-1:0] per;

  logic [CNT_W-1:0] cnt_eff;
  logic accept;
  logic poll_go;
  logic ram_we;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [FREQ_W-1:0] rd_freq;
  logic [DUR_W-1:0] rd_dur;
  logic tone_ok;
  logic [PER_W:0] psc_raw;
  logic [PSC_W-1:0] psc_sat;
  logic idx_wrap;
  logic [AW-1:0] idx_adv;

  mtps_div_req_t div_req;
  mtps_div_rsp_t div_rsp;
  mtps_mul_req_t mul_req;
  mtps_mul_rsp_t mul_rsp;

  assign busy = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept = start && !busy;
  assign cnt_eff = (32'(melody_count) > TONE_DEPTH) ? CNT_W'(TONE_DEPTH) : melody_count;
  assign poll_go = accept && (command.operation == OP_POLL) && command.playback_enabled
                   && (command.time_now_ms > end_time) && (cnt_eff != '0);
  assign ram_we = accept && (command.operation == OP_WRITE)
                  && (32'(command.entry_address) < TONE_DEPTH);

  assign rd_freq = ram_rdata[ENTRY_W-1:DUR_W];
  assign rd_dur = ram_rdata[DUR_W-1:0];
  assign tone_ok = (rd_freq != '0) && (32'(rd_freq) <= MAX_TONE_HZ);

  assign psc_raw = {1'b0, div_rsp.quot[PER_W-1:0]} + (PER_W+1)'(1);
  assign psc_sat = (psc_raw > (PER_W+1)'(PSC_MAX)) ? PSC_MAX : psc_raw[PSC_W-1:0];

  assign idx_wrap = ((32'(idx) + 32'd1) >= 32'(cnt_eff));
  assign idx_adv = idx_wrap ? '0 : idx + AW'(1);

  mtps_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TONE_DEPTH)
  ) u_ram (
    .clk(clk),
    .we(ram_we),
    .waddr(AW'(command.entry_address)),
    .wdata({command.entry_frequency, command.entry_duration}),
    .raddr(div_rsp.rem[AW-1:0]),
    .rdata(ram_rdata)
  );

  mtps_div u_div (
    .clk(clk),
    .rst(rst),
    .req(div_req),
    .rsp(div_rsp)
  );

  mtps_mul u_mul (
    .clk(clk),
    .rst(rst),
    .req(mul_req),
    .rsp(mul_rsp)
  );

  always_comb begin
    div_req = '{start: 1'b0, dividend: '0, divisor: '0, len: '0};
    unique case (state)
      ST_IDLE: begin
        div_req = '{start: poll_go, dividend: DIV_W'(tone_index),
                    divisor: DIVR_W'(cnt_eff), len: LEN_W'(AW)};
      end
      ST_DATA: begin
        div_req = '{start: tone_ok, dividend: DIV_W'(clock_hz),
                    divisor: rd_freq, len: WORD_LEN};
      end
      ST_Q1: begin
        div_req = '{start: div_rsp.done, dividend: div_rsp.quot,
                    divisor: PSC_DIVISOR, len: WORD_LEN};
      end
      ST_PSC: begin
        div_req = '{start: div_rsp.done, dividend: DIV_W'(clock_hz),
                    divisor: psc_sat, len: WORD_LEN};
      end
      ST_PER: begin
        div_req = '{start: div_rsp.done, dividend: div_rsp.quot,
                    divisor: freq, len: WORD_LEN};
      end
      ST_MUL: begin
        div_req = '{start: mul_rsp.done, dividend: mul_rsp.product,
                    divisor: CMP_DIVISOR, len: PROD_LEN};
      end
      default: begin
      end
    endcase
  end

  assign mul_req = '{start: (state == ST_FREQ) && div_rsp.done, multiplier: volume,
                     multiplicand: div_rsp.quot[PER_W-1:0]};

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (poll_go) state_next = ST_MOD;
      ST_MOD:  if (div_rsp.done) state_next = ST_DATA;
      ST_DATA: state_next = tone_ok ? ST_Q1 : ST_IDLE;
      ST_Q1:   if (div_rsp.done) state_next = ST_PSC;
      ST_PSC:  if (div_rsp.done) state_next = ST_PER;
      ST_PER:  if (div_rsp.done) state_next = ST_FREQ;
      ST_FREQ: if (div_rsp.done) state_next = ST_MUL;
      ST_MUL:  if (mul_rsp.done) state_next = ST_CMP;
      ST_CMP:  if (div_rsp.done) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      clock_hz <= RST_CLOCK_HZ;
      volume <= RST_VOLUME;
      melody_count <= RST_COUNT;
      tone_index <= '0;
      end_time <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      result_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_CLOCK_HZ: clock_hz <= cfg_data;
          CFG_VOLUME:   volume <= cfg_data[VOL_W-1:0];
          CFG_COUNT:    melody_count <= cfg_data[CNT_W-1:0];
          default: begin
          end
        endcase
      end
      if (accept && (command.operation == OP_RESTART)) begin
        tone_index <= '0;
      end
      if ((state == ST_DATA) && !tone_ok) begin
        result_valid <= 1'b1;
        end_time <= now + TIME_W'(rd_dur);
        tone_index <= idx_adv;
      end
      if ((state == ST_CMP) && div_rsp.done) begin
        result_valid <= 1'b1;
        end_time <= now + TIME_W'(dur);
        tone_index <= idx_adv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (poll_go) begin
      now <= command.time_now_ms;
    end
    if ((state == ST_MOD) && div_rsp.done) begin
      idx <= div_rsp.rem[AW-1:0];
    end
    if (state == ST_DATA) begin
      freq <= rd_freq;
      dur <= rd_dur;
      if (!tone_ok) begin
        result <= '{timer_update: 1'b0, prescaler_minus_one: '0, period_minus_one: '0,
                    compare_value: '0, played_index: ADDR_W'(idx)};
      end
    end
    if ((state == ST_PSC) && div_rsp.done) begin
      psc <= psc_sat;
    end
    if ((state == ST_FREQ) && div_rsp.done) begin
      per <= div_rsp.quot[PER_W-1:0];
    end
    if ((state == ST_CMP) && div_rsp.done) begin
      result <= '{timer_update: 1'b1,
                  prescaler_minus_one: psc - PSC_W'(1),
                  period_minus_one: OUT_W'(per) - OUT_W'(1),
                  compare_value: div_rsp.quot[OUT_W-1:0],
                  played_index: ADDR_W'(idx)};
    end
  end

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ($past(state) == ST_CMP || $past(state) == ST_DATA))
    else $error("result beat without a finished tone computation");

  a_rest_silent: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.timer_update) |->
      (result.prescaler_minus_one == '0 && result.period_minus_one == '0
       && result.compare_value == '0))
    else $error("rest beat carries nonzero timer values");

  a_div_owned: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state != ST_IDLE))
    else $error("divider finished while the sequencer was idle");

  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    (accept && command.operation == OP_WRITE) |=> (!result_valid && state == ST_IDLE))
    else $error("tone write started playback");

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
  import mtps_pkg::*;

  localparam int MEM_DEPTH = DEF_TONE_DEPTH;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 200;
  localparam int MAX_GAP = 60;
  localparam int MAX_REPORTS = 10;
  localparam longint unsigned VOLUME_SCALE = 1000;
  localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;
  localparam logic [CLK_W-1:0] CLOCK_HZ_MAX = '1;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  mtps_cmd_t command;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CLK_W-1:0] cfg_data;
  logic result_valid;
  mtps_result_t result;

  logic [ENTRY_W-1:0] melody_mem [MEM_DEPTH];
  bit melody_loaded [MEM_DEPTH];
  logic [ADDR_W-1:0] play_pos;
  logic [TIME_W-1:0] tone_deadline;
  logic [CLK_W-1:0] clock_hz_reg;
  logic [VOL_W-1:0] volume_reg;
  logic [CNT_W-1:0] count_reg;
  mtps_result_t tones_due[$];
  mtps_result_t tone_want;

  int mismatches;
  int items_sent;
  int tones_checked;
  int rests_checked;
  int cfg_writes;
  int idle_pct;
  int quiet_cycles;

  melody_tone_pwm_sequencer_top DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .command(command),
    .busy(busy),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .result_valid(result_valid),
    .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int unsigned melody_len();
    return (count_reg > MEM_DEPTH) ? MEM_DEPTH : count_reg;
  endfunction

  function automatic bit poll_plays(input mtps_cmd_t c);
    return c.playback_enabled && (c.time_now_ms > tone_deadline) && (melody_len() != 0);
  endfunction

  function automatic mtps_result_t tone_timer(input logic [FREQ_W-1:0] freq,
                                              input logic [ADDR_W-1:0] idx);
    longint unsigned hz;
    longint unsigned psc;
    longint unsigned per;
    longint unsigned cmp;
    mtps_result_t r;
    r = '0;
    r.played_index = idx;
    if (freq != 0 && freq <= MAX_TONE_HZ) begin
      hz = 64'(clock_hz_reg);
      psc = 1 + hz / freq / PSC_DIVISOR;
      if (psc > PSC_MAX) begin
        psc = PSC_MAX;
      end
      per = hz / psc / freq;
      cmp = volume_reg * per / VOLUME_SCALE / 2;
      r.timer_update = 1'b1;
      r.prescaler_minus_one = PSC_W'(psc - 1);
      r.period_minus_one = OUT_W'(per - 1);
      r.compare_value = OUT_W'(cmp);
    end
    return r;
  endfunction

  task automatic play_command(input mtps_cmd_t c);
    int unsigned n;
    logic [ADDR_W-1:0] idx;
    logic [ENTRY_W-1:0] entry;
    case (c.operation)
      OP_WRITE: begin
        melody_mem[c.entry_address] = {c.entry_frequency, c.entry_duration};
        melody_loaded[c.entry_address] = 1'b1;
      end
      OP_RESTART: begin
        play_pos = '0;
      end
      OP_POLL: begin
        if (poll_plays(c)) begin
          n = melody_len();
          idx = ADDR_W'(play_pos % n);
          entry = melody_mem[idx];
          tones_due.push_back(tone_timer(entry[ENTRY_W-1:DUR_W], idx));
          tone_deadline = c.time_now_ms + entry[DUR_W-1:0];
          play_pos = (idx + 1 >= n) ? '0 : idx + ADDR_W'(1);
        end
      end
      default: ;
    endcase
  endtask

  function automatic mtps_cmd_t poll_cmd(input logic [TIME_W-1:0] t, input logic en);
    mtps_cmd_t c;
    c = '0;
    c.operation = OP_POLL;
    c.time_now_ms = t;
    c.playback_enabled = en;
    return c;
  endfunction

  function automatic mtps_cmd_t write_cmd(input logic [ADDR_W-1:0] addr,
                                          input logic [FREQ_W-1:0] freq,
                                          input logic [DUR_W-1:0] dur);
    mtps_cmd_t c;
    c = '0;
    c.operation = OP_WRITE;
    c.entry_address = addr;
    c.entry_frequency = freq;
    c.entry_duration = dur;
    return c;
  endfunction

  function automatic mtps_cmd_t op_cmd(input logic [OP_W-1:0] op);
    mtps_cmd_t c;
    c = '1;
    c.operation = op;
    return c;
  endfunction

  // Mostly polls timed just past the current tone, so the melody keeps advancing.
  function automatic mtps_cmd_t random_command();
    mtps_cmd_t c;
    int unsigned pick;
    int unsigned n;
    logic [ADDR_W-1:0] idx;
    logic [TIME_W-1:0] t;
    c.operation = OP_POLL;
    c.time_now_ms = $urandom;
    c.playback_enabled = 1'($urandom_range(1));
    c.entry_address = ADDR_W'($urandom);
    c.entry_frequency = FREQ_W'($urandom);
    c.entry_duration = DUR_W'($urandom);
    n = melody_len();
    pick = $urandom_range(99);
    if (pick < 18) begin
      c.operation = OP_WRITE;
      if (n != 0 && $urandom_range(3) != 0) begin
        c.entry_address = ADDR_W'($urandom_range(n - 1));
      end
      case ($urandom_range(9))
        0: c.entry_frequency = '0;
        1: c.entry_frequency = FREQ_W'($urandom_range(65535, MAX_TONE_HZ + 1));
        2: c.entry_frequency = FREQ_W'($urandom_range(20, 1));
        3: ;
        default: c.entry_frequency = FREQ_W'($urandom_range(MAX_TONE_HZ, 1));
      endcase
      if ($urandom_range(4) != 0) begin
        c.entry_duration = DUR_W'($urandom_range(400));
      end
    end else if (pick < 23) begin
      c.operation = OP_RESTART;
    end else if (pick < 26) begin
      c.operation = OP_IGNORED;
    end else begin
      c.playback_enabled = ($urandom_range(9) != 0);
      pick = $urandom_range(99);
      if (pick < 75) begin
        t = tone_deadline + 1 + $urandom_range(40);
        if (t <= tone_deadline) begin
          t = '1;
        end
        c.time_now_ms = t;
      end else if (pick < 88) begin
        c.time_now_ms = tone_deadline - $urandom_range(30);
      end
      if (poll_plays(c)) begin
        idx = ADDR_W'(play_pos % n);
        if (!melody_loaded[idx]) begin
          c.operation = OP_WRITE;
          c.entry_address = idx;
        end
      end
    end
    return c;
  endfunction

  task automatic send_command(input mtps_cmd_t c);
    int gap;
    @(negedge clk);
    start <= 1'b1;
    command <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    play_command(c);
    items_sent++;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic settle(input bit linger);
    @(negedge clk);
    start <= 1'b0;
    while (tones_due.size() != 0) @(posedge clk);
    if (linger) begin
      repeat (SETTLE_CYCLES) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CLK_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_CLOCK_HZ: clock_hz_reg = value;
      CFG_VOLUME: volume_reg = VOL_W'(value);
      CFG_COUNT: count_reg = CNT_W'(value);
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(input logic [CLK_W-1:0] hz, input logic [VOL_W-1:0] vol,
                           input logic [CNT_W-1:0] cnt);
    settle(1'b1);
    write_reg(CFG_CLOCK_HZ, hz);
    write_reg(CFG_VOLUME, CLK_W'(vol));
    write_reg(CFG_COUNT, CLK_W'(cnt));
  endtask

  task automatic test_empty_melody();
    idle_pct = 0;
    send_command(poll_cmd(32'd10, 1'b1));
    send_command(write_cmd(6'd0, 16'd440, 16'd100));
    send_command(poll_cmd(32'd20, 1'b1));
    settle(1'b1);
  endtask

  task automatic test_tone_sequence();
    configure(RST_CLOCK_HZ, RST_VOLUME, 7'd4);
    send_command(write_cmd(6'd1, 16'd0, 16'd0));
    send_command(write_cmd(6'd2, 16'(MAX_TONE_HZ + 1), 16'hFFFF));
    send_command(write_cmd(6'd3, 16'(MAX_TONE_HZ), 16'd1));
    send_command(write_cmd(6'd63, 16'hFFFF, 16'hFFFF));
    send_command(poll_cmd(32'd0, 1'b1));
    send_command(poll_cmd(32'd1, 1'b0));
    send_command(poll_cmd(32'd1, 1'b1));
    send_command(poll_cmd(32'd50, 1'b1));
    send_command(poll_cmd(32'd102, 1'b1));
    send_command(poll_cmd(32'd103, 1'b1));
    send_command(poll_cmd(32'hFFFF_FFFF, 1'b1));
    send_command(poll_cmd(32'd1, 1'b1));
    send_command(op_cmd(OP_RESTART));
    send_command(op_cmd(OP_IGNORED));
    send_command(poll_cmd(32'hFFFF_FFF0, 1'b1));
    send_command(poll_cmd(32'h0000_0055, 1'b1));
    settle(1'b1);
  endtask

  task automatic test_clock_extremes();
    configure('0, 10'h3FF, 7'h7F);
    send_command(op_cmd(OP_RESTART));
    send_command(poll_cmd(tone_deadline + 1, 1'b1));
    configure(CLOCK_HZ_MAX, '0, 7'd2);
    send_command(op_cmd(OP_RESTART));
    send_command(poll_cmd(tone_deadline + 1, 1'b1));
    configure(29'd300, 10'd1000, 7'd1);
    send_command(poll_cmd(tone_deadline + 1, 1'b1));
    send_command(poll_cmd(tone_deadline + 1, 1'b1));
    settle(1'b1);
  endtask

  task automatic test_random_traffic(input int items, input int pct,
                                     input logic [CLK_W-1:0] hz,
                                     input logic [VOL_W-1:0] vol,
                                     input logic [CNT_W-1:0] cnt);
    configure(hz, vol, cnt);
    idle_pct = pct;
    repeat (items) begin
      if ($urandom_range(49) == 0) begin
        settle(1'b0);
      end
      send_command(random_command());
    end
    settle(1'b1);
    idle_pct = 0;
  endtask

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%0t: %s", $realtime, msg);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (tones_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result beat %p", result));
      end else begin
        tone_want = tones_due.pop_front();
        if (result.timer_update !== tone_want.timer_update ||
            result.prescaler_minus_one !== tone_want.prescaler_minus_one ||
            result.period_minus_one !== tone_want.period_minus_one ||
            result.compare_value !== tone_want.compare_value ||
            result.played_index !== tone_want.played_index) begin
          report_mismatch($sformatf("result mismatch: expected %p, got %p", tone_want, result));
        end
        if (tone_want.timer_update) begin
          tones_checked++;
        end else begin
          rests_checked++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no beat for %0d cycles, %0d results outstanding.",
               quiet_cycles, tones_due.size());
      $display("FAIL melody_tone_pwm_sequencer_top");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    start = 1'b0;
    command = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_CLOCK_HZ;
    cfg_data = '0;
    idle_pct = 0;
    quiet_cycles = 0;
    mismatches = 0;
    items_sent = 0;
    tones_checked = 0;
    rests_checked = 0;
    cfg_writes = 0;
    play_pos = '0;
    tone_deadline = '0;
    clock_hz_reg = RST_CLOCK_HZ;
    volume_reg = RST_VOLUME;
    count_reg = RST_COUNT;
    for (int i = 0; i < MEM_DEPTH; i++) begin
      melody_mem[i] = '0;
      melody_loaded[i] = 1'b0;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_melody();
    test_tone_sequence();
    test_clock_extremes();
    test_random_traffic(200, 0, 29'd72000000, 10'd500, 7'd8);
    test_random_traffic(200, 85, CLOCK_HZ_MAX, 10'h3FF, 7'h7F);
    test_random_traffic(200, 30, 29'd1000000, 10'd1000, 7'd64);
    test_random_traffic(200, 0, 29'd15000, 10'd700, 7'd1);
    test_random_traffic(200, 30, 29'd500000000, 10'd0, 7'd33);

    $display("Run covered %0d commands, %0d tones and %0d rests checked, %0d register writes.",
             items_sent, tones_checked, rests_checked, cfg_writes);
    $display("Clock swept from 0 to full scale, volume 0 to 1023, melody length 0 to 127.");
    if (mismatches == 0 && tones_due.size() == 0) begin
      $display("PASS melody_tone_pwm_sequencer_top");
    end else begin
      $display("%0d mismatches, %0d results never arrived.", mismatches, tones_due.size());
      $display("FAIL melody_tone_pwm_sequencer_top");
    end
    $finish;
  end

endmodule
